### rtl/min_tracking_stack_assert.svh
// ----------------------------------------------------------------------------
// min_tracking_stack assertion macros
// shared concurrent check forms, clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// same-cycle implication
`define MTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min_tracking_stack check failed");

// next-cycle implication
`define MTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min_tracking_stack check failed");

`endif

### rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// types and codes shared by the min tracking stack controller and datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

  localparam int DATA_W = 32;

  // operation codes on in_kind
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } mts_status_t;

  typedef enum logic {
    S_IDLE,
    S_POP
  } mts_state_t;

  // controller to datapath
  typedef struct packed {
    logic        push;      // write value onto the stacks
    logic        read;      // fetch the entries below the tops
    logic        pop;       // retire the tops using fetched entries
    logic        load_out;  // capture a result
    mts_status_t status;
  } mts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } mts_stat_t;

endpackage

### rtl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// request sequencing and result valid for the min tracking stack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_tracking_stack_assert.svh"

module mts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  output logic                out_valid,
  input  logic                out_stall,
  input  mts_pkg::mts_stat_t  stat,
  output mts_pkg::mts_cmd_t   cmd
);
  import mts_pkg::*;

  mts_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = ST_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_PUSH) begin
            cmd.load_out = 1'b1;
            if (stat.full) begin
              cmd.status = ST_PUSH_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (stat.empty) begin
            cmd.load_out = 1'b1;
            cmd.status   = ST_POP_EMPTY;
          end else begin
            cmd.read  = 1'b1;
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          cmd.pop      = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  `MTS_ASSERT_IMPL(a_no_accept_in_pop, state_r == S_POP, in_stall)
  `MTS_ASSERT_NEXT(a_pop_read_then_finish,
                   accept && in_kind == KIND_POP && !stat.empty, state_r == S_POP)
  `MTS_ASSERT_NEXT(a_pop_finish_shows_result, state_r == S_POP && out_free,
                   state_r == S_IDLE && out_valid_r)

endmodule

### rtl/mts_datapath.sv
// ----------------------------------------------------------------------------
// mts_datapath
// stack memories, cached tops, counters and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_tracking_stack_assert.svh"

module mts_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [mts_pkg::DATA_W-1:0] in_value,
  input  mts_pkg::mts_cmd_t                 cmd,
  output mts_pkg::mts_stat_t                stat,
  output logic signed [mts_pkg::DATA_W-1:0] out_top_value,
  output logic signed [mts_pkg::DATA_W-1:0] out_min_value,
  output logic                              out_is_empty,
  output logic [1:0]                        out_status
);
  import mts_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic signed [DATA_W-1:0] data_mem [STACK_DEPTH];
  logic signed [DATA_W-1:0] min_mem  [STACK_DEPTH];

  logic [CW-1:0] dc_r, dc_nxt, mc_r, mc_nxt;
  logic [CW-1:0] dc_m2, mc_m2;
  logic signed [DATA_W-1:0] data_top_r, data_top_nxt, min_top_r, min_top_nxt;
  logic signed [DATA_W-1:0] data_rd_r, min_rd_r;
  logic signed [DATA_W-1:0] top_out_r, top_out_nxt, min_out_r, min_out_nxt;
  logic        empty_out_r, empty_out_nxt;
  mts_status_t status_out_r, status_out_nxt;
  logic        min_take, min_drop;
  logic [CW-1:0] mc_after;

  assign dc_m2 = dc_r - CW'(2);
  assign mc_m2 = mc_r - CW'(2);

  assign stat.full  = (dc_r == CW'(STACK_DEPTH));
  assign stat.empty = (dc_r == '0);

  // new value joins the min stack when it is a new minimum or a tie
  assign min_take = (mc_r == '0) || (min_top_r >= in_value);
  // removed word leaves the min stack when it is the current minimum
  assign min_drop = (mc_r != '0) && (min_top_r == data_top_r);
  assign mc_after = min_drop ? (mc_r - CW'(1)) : mc_r;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      data_mem[dc_r[AW-1:0]] <= in_value;
      if (min_take) begin
        min_mem[mc_r[AW-1:0]] <= in_value;
      end
    end
    if (cmd.read) begin
      data_rd_r <= data_mem[dc_m2[AW-1:0]];
      min_rd_r  <= min_mem[mc_m2[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r <= '0;
      mc_r <= '0;
    end else begin
      dc_r <= dc_nxt;
      mc_r <= mc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_top_r   <= data_top_nxt;
    min_top_r    <= min_top_nxt;
    top_out_r    <= top_out_nxt;
    min_out_r    <= min_out_nxt;
    empty_out_r  <= empty_out_nxt;
    status_out_r <= status_out_nxt;
  end

  always_comb begin
    dc_nxt         = dc_r;
    mc_nxt         = mc_r;
    data_top_nxt   = data_top_r;
    min_top_nxt    = min_top_r;
    top_out_nxt    = top_out_r;
    min_out_nxt    = min_out_r;
    empty_out_nxt  = empty_out_r;
    status_out_nxt = status_out_r;
    if (cmd.push) begin
      dc_nxt       = dc_r + CW'(1);
      data_top_nxt = in_value;
      if (min_take) begin
        mc_nxt      = mc_r + CW'(1);
        min_top_nxt = in_value;
      end
    end else if (cmd.pop) begin
      dc_nxt       = dc_r - CW'(1);
      data_top_nxt = data_rd_r;
      mc_nxt       = mc_after;
      if (min_drop) begin
        min_top_nxt = min_rd_r;
      end
    end
    if (cmd.load_out) begin
      status_out_nxt = cmd.status;
      if (cmd.push) begin
        top_out_nxt   = in_value;
        min_out_nxt   = min_take ? in_value : min_top_r;
        empty_out_nxt = 1'b0;
      end else if (cmd.pop) begin
        if (dc_r == CW'(1)) begin
          top_out_nxt   = '0;
          min_out_nxt   = '0;
          empty_out_nxt = 1'b1;
        end else begin
          top_out_nxt   = data_rd_r;
          empty_out_nxt = 1'b0;
          if (mc_after == '0) begin
            min_out_nxt = '0;
          end else begin
            min_out_nxt = min_drop ? min_rd_r : min_top_r;
          end
        end
      end else if (dc_r == '0) begin
        top_out_nxt   = '0;
        min_out_nxt   = '0;
        empty_out_nxt = 1'b1;
      end else begin
        top_out_nxt   = data_top_r;
        min_out_nxt   = (mc_r != '0) ? min_top_r : '0;
        empty_out_nxt = 1'b0;
      end
    end
  end

  assign out_top_value = top_out_r;
  assign out_min_value = min_out_r;
  assign out_is_empty  = empty_out_r;
  assign out_status    = status_out_r;

  `MTS_ASSERT_IMPL(a_min_not_deeper, 1'b1, mc_r <= dc_r)
  `MTS_ASSERT_IMPL(a_min_empty_with_data, 1'b1, (mc_r == '0) == (dc_r == '0))
  `MTS_ASSERT_IMPL(a_count_in_range, 1'b1, dc_r <= CW'(STACK_DEPTH))

endmodule

### rtl/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// lifo stack of signed words that reports its running minimum
// ----------------------------------------------------------------------------
// Each request is a push (in_kind 0) or a pop (in_kind 1) and yields exactly
// one result: the top after the operation, the smallest value held, an empty
// flag and a status (0 done, 1 pop on empty ignored, 2 push on full
// rejected). Top and minimum read as zero when the stack is empty. A push,
// a rejected push and an ignored pop capture a result when taken and can
// arrive back to back; a pop that removes a word first fetches the entries
// below the cached tops from the stack memories' registered read port, then
// retires them, taking no new request in between. A result register sits
// at the output, so a new request is taken while the previous result waits,
// as long as the result register frees up in that cycle. No clearing pass
// runs after reset: the counters alone mark which memory entries are live.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack #(
  parameter int STACK_DEPTH = 64  // entries in each stack memory, 2 to 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic signed [mts_pkg::DATA_W-1:0] in_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mts_pkg::DATA_W-1:0] out_top_value,
  output logic signed [mts_pkg::DATA_W-1:0] out_min_value,
  output logic                              out_is_empty,
  output logic [1:0]                        out_status
);
  import mts_pkg::*;

  // command and status bundles between sequencer and datapath
  mts_cmd_t  cmd;
  mts_stat_t stat;

  // sequencer: decides push, fetch, pop and when a result is captured
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: data and min stack memories, cached tops, result register
  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_top_value (out_top_value),
    .out_min_value (out_min_value),
    .out_is_empty  (out_is_empty),
    .out_status    (out_status)
  );

endmodule

### tb/min_tracking_stack_check.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_check
// shadow stack that predicts each result and compares it with the block
// ----------------------------------------------------------------------------
// Watches both channels. Every accepted request updates a shadow data stack
// and a shadow minimum stack and queues the view of the stack that should
// come back. Every accepted result is compared with the oldest queued view.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack_check #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_kind,
  input  logic signed [mts_pkg::DATA_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [mts_pkg::DATA_W-1:0] out_top_value,
  input  logic signed [mts_pkg::DATA_W-1:0] out_min_value,
  input  logic                              out_is_empty,
  input  logic [1:0]                        out_status,
  output int                                mismatches,
  output int                                outstanding
);
  import mts_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    mts_status_t              status;
  } stack_view_t;

  logic signed [DATA_W-1:0] shadow_data [STACK_DEPTH];
  logic signed [DATA_W-1:0] shadow_min [STACK_DEPTH];
  int                       data_depth = 0;
  int                       min_depth = 0;
  stack_view_t              pending_views [$];
  stack_view_t              want;
  int                       mismatch_count = 0;
  int                       result_index = 0;

  assign mismatches = mismatch_count;
  initial outstanding = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // apply one request to the shadow stacks and queue the resulting view
  task automatic track_request(input logic kind, input logic signed [DATA_W-1:0] value);
    stack_view_t              view;
    logic signed [DATA_W-1:0] removed;
    view.status = ST_DONE;
    if (kind == KIND_PUSH) begin
      if (data_depth >= STACK_DEPTH) begin
        view.status = ST_PUSH_FULL;
      end else begin
        shadow_data[data_depth] = value;
        data_depth++;
        if (min_depth == 0 || shadow_min[min_depth - 1] >= value) begin
          shadow_min[min_depth] = value;
          min_depth++;
        end
      end
    end else if (data_depth == 0) begin
      view.status = ST_POP_EMPTY;
    end else begin
      data_depth--;
      removed = shadow_data[data_depth];
      if (min_depth != 0 && shadow_min[min_depth - 1] == removed) min_depth--;
    end
    if (data_depth == 0) begin
      view.top_value = '0;
      view.min_value = '0;
      view.is_empty  = 1'b1;
    end else begin
      view.top_value = shadow_data[data_depth - 1];
      view.min_value = (min_depth != 0) ? shadow_min[min_depth - 1] : '0;
      view.is_empty  = 1'b0;
    end
    pending_views.push_back(view);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      data_depth = 0;
      min_depth  = 0;
      pending_views.delete();
    end else begin
      // a result leaving now belongs to an earlier request, so check first
      if (out_valid && !out_stall) begin
        if (pending_views.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request waiting",
                                    result_index));
        end else begin
          want = pending_views.pop_front();
          if (out_top_value !== want.top_value)
            report_mismatch($sformatf("result %0d top_value got %0d expected %0d",
                                      result_index, out_top_value, want.top_value));
          if (out_min_value !== want.min_value)
            report_mismatch($sformatf("result %0d min_value got %0d expected %0d",
                                      result_index, out_min_value, want.min_value));
          if (out_is_empty !== want.is_empty)
            report_mismatch($sformatf("result %0d is_empty got %b expected %b",
                                      result_index, out_is_empty, want.is_empty));
          if (out_status !== want.status)
            report_mismatch($sformatf("result %0d status got %0d expected %0d",
                                      result_index, out_status, want.status));
        end
        result_index++;
      end
      if (in_valid && !in_stall) track_request(in_kind, in_value);
    end
    outstanding <= pending_views.size();
  end

endmodule

### tb/min_tracking_stack_test.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_test
// request stimulus and verdict for the min tracking stack
// ----------------------------------------------------------------------------
// A short directed run covers the value extremes, equal minimums and pops
// on an empty stack, then a fill past the top covers rejected pushes. The
// rest is random bursts that lean toward filling, draining or mixing, with
// random gaps on the request side and random stalls on the result side. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack_test;
  import mts_pkg::*;

  localparam int STACK_DEPTH  = 64;
  localparam int ITEM_TARGET  = 550;   // requests counted, pops on an empty stack apart
  localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 20;    // settle time once nothing is pending

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_kind = KIND_PUSH;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_top_value;
  logic signed [DATA_W-1:0] out_min_value;
  logic                     out_is_empty;
  logic [1:0]               out_status;

  int fail_count;
  int outstanding;

  // sender bookkeeping: a plain occupancy count steers the bursts
  int  depth_est = 0;
  int  counted = 0;
  bit  quiet_sender = 1'b0;

  // result side stall pattern
  int  free_left = 0;
  int  stall_left = 0;

  // watchdog
  int  idle_cycles = 0;

  always #4 clk = ~clk;

  min_tracking_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_top_value(out_top_value),
    .out_min_value(out_min_value),
    .out_is_empty (out_is_empty),
    .out_status   (out_status)
  );

  min_tracking_stack_check #(
    .STACK_DEPTH(STACK_DEPTH)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_top_value(out_top_value),
    .out_min_value(out_min_value),
    .out_is_empty (out_is_empty),
    .out_status   (out_status),
    .mismatches   (fail_count),
    .outstanding  (outstanding)
  );

  // mostly back to back, sometimes a few cycles, rarely a long hole
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // small values give many ties on the minimum, extremes hit the signed
  // compare edges, full random words toggle every bit
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return DATA_W'(int'($urandom_range(0, 8)) - 4);
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // hold a request until the block takes it; valid only drops for a gap or a drain
  task automatic send_request(input logic kind, input logic signed [DATA_W-1:0] value);
    int gap;
    gap = quiet_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    // pops on an empty stack are ignored by the block, so they do not count
    if (kind == KIND_PUSH) begin
      counted++;
      if (depth_est < STACK_DEPTH) depth_est++;
    end else if (depth_est > 0) begin
      counted++;
      depth_est--;
    end
  endtask

  task automatic push_word(input logic signed [DATA_W-1:0] value);
    send_request(KIND_PUSH, value);
  endtask

  // the pop value is don't care, so it carries noise
  task automatic pop_word();
    send_request(KIND_POP, $urandom);
  endtask

  // stop sending until every queued result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // result side: a free stretch then a stall stretch, redrawn each round
  always @(posedge clk) begin
    if (!rst_n) begin
      free_left  = 0;
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      // now and then a long stretch with no stall at all
      free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
                                              : $urandom_range(0, 4);
      case ($urandom_range(0, 19))
        0:          stall_left = $urandom_range(20, 40);
        1, 2, 3:    stall_left = $urandom_range(4, 10);
        default:    stall_left = $urandom_range(1, 3);
      endcase
      out_stall <= 1'b0;
    end
  end

  // watchdog: any handshake on either side resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int mode;
    int burst_len;
    int pop_weight;
    logic kind;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pop on empty, extremes, tied minimums, unwinding to empty
    pop_word();
    push_word('0);
    push_word(WORD_MAX);
    push_word(WORD_MIN);        // new minimum at the most negative word
    push_word(WORD_MIN);        // equal to the minimum, stacks a second copy
    push_word('1);
    pop_word();                 // minimum stays put
    pop_word();                 // drops one copy of the tied minimum
    pop_word();                 // minimum returns to zero
    pop_word();
    pop_word();                 // back to empty
    pop_word();                 // ignored pop again
    push_word(32'sd5);
    push_word(32'sd5);
    push_word(32'sd7);
    pop_word();
    pop_word();
    pop_word();
    push_word('1);
    push_word(32'sd1);          // larger value leaves the minimum alone
    push_word(WORD_MAX);
    pop_word();
    pop_word();
    pop_word();

    // let the pipeline empty out completely once
    wait_drained();

    // fill past the top so pushes get rejected while full
    repeat (STACK_DEPTH + 4) push_word(pick_value());
    repeat (STACK_DEPTH + 2) pop_word();

    // random bursts that lean toward filling, draining or a mix
    while (counted < ITEM_TARGET) begin
      mode = $urandom_range(0, 2);
      burst_len = $urandom_range(8, 80);
      quiet_sender = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) wait_drained();
      case (mode)
        0:       pop_weight = 1;   // filling
        1:       pop_weight = 7;   // draining
        default: pop_weight = 4;   // mixed
      endcase
      for (int i = 0; i < burst_len && counted < ITEM_TARGET; i++) begin
        kind = ($urandom_range(0, 7) < pop_weight) ? KIND_POP : KIND_PUSH;
        if (kind == KIND_POP) pop_word();
        else push_word(pick_value());
      end
    end

    // done sending: wait for the last results, then settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
